// ----- src/wcp_pkg.sv -----
// Shared types, microcode ROM and condition decode for the windowed
// co-occurrence pair block. Depends on nothing; the sequencer, datapath and top level import it.
`timescale 1ns / 1ps

package wcp_pkg;

    // Default sizes for the top-level parameters.
    localparam int WINDOW_DEF  = 10;
    localparam int ID_BITS_DEF = 8;

    // Program steps of the sequencer.
    typedef enum logic [2:0] {
        STEP_WAIT   = 3'd0,
        STEP_CHECK  = 3'd1,
        STEP_SCAN   = 3'd2,
        STEP_SHIFT  = 3'd3,
        STEP_FINISH = 3'd4
    } step_t;

    // Condition codes used for both the wait and the branch fields.
    typedef enum logic [2:0] {
        COND_ALWAYS    = 3'd0,
        COND_NEVER     = 3'd1,
        COND_IN_VALID  = 3'd2,
        COND_NO_MAIN   = 3'd3,
        COND_SCAN_GO   = 3'd4,
        COND_SCAN_MORE = 3'd5,
        COND_FINISH_GO = 3'd6
    } cond_t;

    // One control word of the program.
    typedef struct packed {
        logic  in_ready;
        cond_t wait_cond;
        cond_t branch_cond;
        step_t branch_target;
        logic  act_insert;
        logic  act_jinit;
        logic  act_scan;
        logic  act_shift;
        logic  act_finish;
    } ctrl_t;

    // Status flags from the datapath that the conditions test.
    typedef struct packed {
        logic in_valid;
        logic main_ready;
        logic scan_go;
        logic scan_more;
        logic finish_go;
    } status_t;

    // Program ROM: one control word per step.
    function automatic ctrl_t ucode_rom(input step_t step);
        ctrl_t w;
        w = '{in_ready: 1'b0, wait_cond: COND_ALWAYS, branch_cond: COND_ALWAYS,
              branch_target: STEP_WAIT, act_insert: 1'b0, act_jinit: 1'b0,
              act_scan: 1'b0, act_shift: 1'b0, act_finish: 1'b0};
        case (step)
            STEP_WAIT:
            begin
                w.in_ready    = 1'b1;
                w.wait_cond   = COND_IN_VALID;
                w.branch_cond = COND_NEVER;
                w.act_insert  = 1'b1;
            end
            STEP_CHECK:
            begin
                w.branch_cond   = COND_NO_MAIN;
                w.branch_target = STEP_FINISH;
                w.act_jinit     = 1'b1;
            end
            STEP_SCAN:
            begin
                w.wait_cond     = COND_SCAN_GO;
                w.branch_cond   = COND_SCAN_MORE;
                w.branch_target = STEP_SCAN;
                w.act_scan      = 1'b1;
            end
            STEP_SHIFT:
            begin
                w.branch_target = STEP_CHECK;
                w.act_shift     = 1'b1;
            end
            STEP_FINISH:
            begin
                w.wait_cond  = COND_FINISH_GO;
                w.act_finish = 1'b1;
            end
            default:
            begin
                w.branch_target = STEP_WAIT;
            end
        endcase
        return w;
    endfunction

    // Evaluate one condition code against the datapath status.
    function automatic logic cond_eval(input cond_t c, input status_t s);
        logic r;
        case (c)
            COND_ALWAYS:    r = 1'b1;
            COND_NEVER:     r = 1'b0;
            COND_IN_VALID:  r = s.in_valid;
            COND_NO_MAIN:   r = !s.main_ready;
            COND_SCAN_GO:   r = s.scan_go;
            COND_SCAN_MORE: r = s.scan_more;
            COND_FINISH_GO: r = s.finish_go;
            default:        r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// ----- src/wcp_sequencer.sv -----
// Microcoded sequencer: step counter, program ROM lookup and conditional jumps.
// Depends on wcp_pkg.
`timescale 1ns / 1ps

module wcp_sequencer
    import wcp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  status_t status,
    output ctrl_t   ctrl,
    output logic    fire
);

    step_t step_reg;
    step_t step_next;
    logic  taken;

    // Output decode: control word of the current step and its qualifiers.
    always_comb
    begin
        ctrl  = ucode_rom(step_reg);
        fire  = cond_eval(ctrl.wait_cond, status);
        taken = cond_eval(ctrl.branch_cond, status);
    end

    // Next step: hold while waiting, jump when the branch is taken.
    always_comb
    begin
        if (!fire)
        begin
            step_next = step_reg;
        end
        else if (taken)
        begin
            step_next = ctrl.branch_target;
        end
        else
        begin
            step_next = step_t'(step_reg + 3'd1);
        end
    end

    // Step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_WAIT;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

// ----- src/wcp_datapath.sv -----
// Datapath: keyword window, fill count, partner index, pair hold stage and
// output register. Driven by the sequencer's control word; depends on wcp_pkg.
`timescale 1ns / 1ps

module wcp_datapath
    import wcp_pkg::*;
#(
    parameter int WINDOW  = WINDOW_DEF,
    parameter int ID_BITS = ID_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  ctrl_t              ctrl,
    input  logic               fire,
    output status_t            status,
    input  logic               in_valid,
    input  logic               in_has_kw,
    input  logic [ID_BITS-1:0] in_id,
    input  logic               in_end,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [ID_BITS-1:0] out_main,
    output logic [ID_BITS-1:0] out_partner,
    output logic               out_last
);

    localparam int FW = $clog2(WINDOW + 1);
    localparam int JW = $clog2(WINDOW);

    logic               win_valid_reg [WINDOW];
    logic [ID_BITS-1:0] win_id_reg    [WINDOW];
    logic [FW-1:0]      fill_reg;
    logic [JW-1:0]      j_reg;
    logic               ends_reg;
    logic               hold_valid_reg;
    logic [ID_BITS-1:0] hold_main_reg;
    logic [ID_BITS-1:0] hold_partner_reg;
    logic               out_valid_reg;
    logic [ID_BITS-1:0] out_main_reg;
    logic [ID_BITS-1:0] out_partner_reg;
    logic               out_last_reg;

    logic               out_free;
    logic               part_valid;
    logic [ID_BITS-1:0] part_id;
    logic               cand;
    logic               do_insert;
    logic               do_scan;
    logic               do_shift;
    logic               do_finish;
    logic               push;
    logic [JW-1:0]      ins_idx;

    // Partner lookup and pair detection against the main in entry zero.
    always_comb
    begin
        out_free   = !out_valid_reg || out_ready;
        part_valid = win_valid_reg[j_reg];
        part_id    = win_id_reg[j_reg];
        cand       = win_valid_reg[0] && part_valid && (win_id_reg[0] != part_id);
        do_insert  = fire && ctrl.act_insert;
        do_scan    = fire && ctrl.act_scan;
        do_shift   = fire && ctrl.act_shift;
        do_finish  = fire && ctrl.act_finish;
        push       = hold_valid_reg && ((do_scan && cand) || do_finish);
        ins_idx    = fill_reg[JW-1:0];
    end

    // Status back to the sequencer.
    always_comb
    begin
        status.in_valid   = in_valid;
        status.main_ready = (fill_reg == FW'(WINDOW)) || (ends_reg && (fill_reg != '0));
        status.scan_go    = !(cand && hold_valid_reg && !out_free);
        status.scan_more  = (FW'(j_reg) + FW'(1)) < fill_reg;
        status.finish_go  = out_free || !hold_valid_reg;
    end

    // Window valid bits, fill count and end flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < WINDOW; k++)
            begin
                win_valid_reg[k] <= 1'b0;
            end
            fill_reg <= '0;
            ends_reg <= 1'b0;
        end
        else
        begin
            if (do_insert)
            begin
                win_valid_reg[ins_idx] <= in_has_kw;
                fill_reg               <= fill_reg + FW'(1);
                ends_reg               <= in_end;
            end
            if (do_shift)
            begin
                for (int k = 0; k < WINDOW - 1; k++)
                begin
                    win_valid_reg[k] <= win_valid_reg[k + 1];
                end
                win_valid_reg[WINDOW-1] <= 1'b0;
                fill_reg                <= fill_reg - FW'(1);
            end
            if (do_finish)
            begin
                ends_reg <= 1'b0;
            end
        end
    end

    // Window ids and partner index.
    always_ff @(posedge clk)
    begin
        if (do_insert)
        begin
            win_id_reg[ins_idx] <= in_id;
        end
        if (do_shift)
        begin
            for (int k = 0; k < WINDOW - 1; k++)
            begin
                win_id_reg[k] <= win_id_reg[k + 1];
            end
        end
        if (fire && ctrl.act_jinit)
        begin
            j_reg <= JW'(1);
        end
        else if (do_scan)
        begin
            j_reg <= j_reg + JW'(1);
        end
    end

    // Hold stage and output register valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (do_scan && cand)
            begin
                hold_valid_reg <= 1'b1;
            end
            else if (do_finish)
            begin
                hold_valid_reg <= 1'b0;
            end
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold and output payload; the last pair of a request leaves from the finish step.
    always_ff @(posedge clk)
    begin
        if (do_scan && cand)
        begin
            hold_main_reg    <= win_id_reg[0];
            hold_partner_reg <= part_id;
        end
        if (push)
        begin
            out_main_reg    <= hold_main_reg;
            out_partner_reg <= hold_partner_reg;
            out_last_reg    <= do_finish;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_main    = out_main_reg;
    assign out_partner = out_partner_reg;
    assign out_last    = out_last_reg;

endmodule

// ----- src/windowed_cooccurrence_pairs.sv -----
// Top level of the windowed keyword co-occurrence pair generator.
// Instantiates wcp_sequencer and wcp_datapath; depends on wcp_pkg.
//
//  Channel  Direction  Handshake           Payload
//  s_*      in         s_tvalid/s_tready   tdata: keyword_id; tuser: has_keyword;
//                                          tlast: article_end
//  m_*      out        m_tvalid/m_tready   tdata: main_id, partner_id; tlast: run_last
//
// A position that does not complete the window passes the wait, check and
// finish steps; one that completes it also scans and shifts, and the partner
// scan of the shared compare unit runs one window entry per cycle while the
// output does not stall it. At an article end each pending main in turn is
// scanned against the held positions and shifted out. A stalled output stops
// the scan only when a second pair is found, and holds the finish step while
// a pair still waits. Reset empties the window and needs no clearing pass.
`timescale 1ns / 1ps

module windowed_cooccurrence_pairs
    import wcp_pkg::*;
#(
    parameter int WINDOW  = WINDOW_DEF,
    parameter int ID_BITS = ID_BITS_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [((ID_BITS+7)/8)*8-1:0]       s_tdata,   // keyword_id
    input  logic                               s_tuser,   // has_keyword
    input  logic                               s_tlast,   // article_end
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [((2*ID_BITS+7)/8)*8-1:0]     m_tdata,   // main_id, partner_id
    output logic                               m_tlast    // run_last
);

    localparam int OUT_DW = ((2 * ID_BITS + 7) / 8) * 8;

    ctrl_t              ctrl;
    status_t            status;
    logic               fire;
    logic [ID_BITS-1:0] out_main;
    logic [ID_BITS-1:0] out_partner;

    // Program sequencer.
    wcp_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl),
        .fire   (fire)
    );

    // Window and pair datapath.
    wcp_datapath #(
        .WINDOW  (WINDOW),
        .ID_BITS (ID_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .fire        (fire),
        .status      (status),
        .in_valid    (s_tvalid),
        .in_has_kw   (s_tuser),
        .in_id       (s_tdata[ID_BITS-1:0]),
        .in_end      (s_tlast),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_main    (out_main),
        .out_partner (out_partner),
        .out_last    (m_tlast)
    );

    // Requests are taken only in the wait step.
    assign s_tready = ctrl.in_ready;
    assign m_tdata  = OUT_DW'({out_partner, out_main});

endmodule

// ----- src/wcp_checker.sv -----
// Port-level checks for windowed_cooccurrence_pairs, attached by bind.
// Depends on the top level's port list only.
`timescale 1ns / 1ps

module wcp_checker #(
    parameter int ID_BITS = 8
)
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [((2*ID_BITS+7)/8)*8-1:0] m_tdata,
    input logic                           m_tlast
);

    // A stalled result keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // A pair never joins two equal ids.
    a_pair_differs: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[ID_BITS-1:0] != m_tdata[2*ID_BITS-1:ID_BITS]))
        else $error("pair with equal ids");

    // After a request is taken the block is busy in the next cycle.
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken in back-to-back cycles");

    // New results are produced only while no request can be taken.
    a_result_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared from the wait step");

endmodule

bind windowed_cooccurrence_pairs wcp_checker #(.ID_BITS(ID_BITS)) u_wcp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
